>>> src/wph_pkg.sv
// ----------------------------------------------------------------------------
// wph_pkg
// shared types and constants of the riff/wave pcm16 header parser
// ----------------------------------------------------------------------------
package wph_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FMT   = 4'd5,
    PH_SKIP  = 4'd6,
    PH_DATA  = 4'd7,
    PH_PAD   = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } chunk_kind_t;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_OK      = 2'd1,
    VERDICT_FAIL    = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TRUNCATED   = 3'd1,
    ERR_NO_RIFF     = 3'd2,
    ERR_NO_WAVE     = 3'd3,
    ERR_UNSUPPORTED = 3'd4,
    ERR_MISSING     = 3'd5,
    ERR_ALIGN       = 3'd6
  } err_t;

  // item class decided by the front part
  typedef enum logic [1:0] {
    OP_BARE     = 2'd0,
    OP_BYTE     = 2'd1,
    OP_END      = 2'd2,
    OP_BYTE_END = 2'd3
  } item_op_t;

  typedef struct packed {
    item_op_t    op;
    logic [7:0]  byte_value;
  } q_entry_t;

  typedef struct packed {
    logic        valid;
    q_entry_t    entry;
  } q_head_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] FMT_BITS     = 16'd16;

endpackage

>>> src/wph_in_if.sv
// ----------------------------------------------------------------------------
// wph_in_if
// input channel: one file byte and/or end marker per beat
// ----------------------------------------------------------------------------
interface wph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       end_of_file;

  modport source (output valid, output byte_value, output has_byte,
                  output end_of_file, input ready);
  modport sink (input valid, input byte_value, input has_byte,
                input end_of_file, output ready);
endinterface

>>> src/wph_out_if.sv
// ----------------------------------------------------------------------------
// wph_out_if
// result channel: audio byte, restart flag, verdict and format fields
// ----------------------------------------------------------------------------
interface wph_out_if;
  logic        valid;
  logic        ready;
  logic        audio_valid;
  logic [7:0]  audio_byte;
  logic        data_restart;
  logic [1:0]  verdict;
  logic [2:0]  error_code;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] avg_byte_rate;
  logic [15:0] block_align;

  modport source (output valid, output audio_valid, output audio_byte,
                  output data_restart, output verdict, output error_code,
                  output channel_count, output sample_rate, output avg_byte_rate,
                  output block_align, input ready);
  modport sink (input valid, input audio_valid, input audio_byte,
                input data_restart, input verdict, input error_code,
                input channel_count, input sample_rate, input avg_byte_rate,
                input block_align, output ready);
endinterface

>>> src/wav_pcm16_header_parser_core.sv
// ----------------------------------------------------------------------------
// wav_pcm16_header_parser_core
// byte-serial riff/wave pcm16 header parser with audio byte forwarding
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per beat: a file byte (has_byte) and/or the end
//   of the file (end_of_file); a beat with neither still yields a result
//   out_ch returns exactly one result beat per input beat, in order: the
//   forwarded data chunk byte (audio_valid), the data restart flag, the
//   running verdict with its error code, and the fmt fields once the verdict
//   is success
//   each item passes through the queue register and then the result
//   register; throughput is one item per cycle while the result receiver
//   takes each result, set by the chunk walker in the back part
//   the front part classifies and queues QUEUE_DEPTH items, so input keeps
//   flowing for that many beats while the result receiver stalls; after that
//   in_ch.ready drops until results are taken
//   an item with end_of_file reports the final verdict and then rearms the
//   parser to its reset state for the next file
//   rst (synchronous, active high) empties the queue and the result register
//   and puts the parser back to expecting the riff tag
// ----------------------------------------------------------------------------
module wav_pcm16_header_parser_core
  import wph_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  wph_in_if.sink     in_ch,
  wph_out_if.source  out_ch
);

  // head of the queue and its pop strobe
  q_head_t head;
  logic    pop;

  wph_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // chunk walker and result register
  wph_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> src/wph_front.sv
// ----------------------------------------------------------------------------
// wph_front
// accepts input beats, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module wph_front
  import wph_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  wph_in_if.sink     in_ch,
  output q_head_t    head,
  input  logic       pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  q_entry_t          entry_in;
  logic              push;
  logic              pop_taken;

  always_comb begin
    entry_in.byte_value = in_ch.byte_value;
    unique case ({in_ch.has_byte, in_ch.end_of_file})
      2'b00:   entry_in.op = OP_BARE;
      2'b10:   entry_in.op = OP_BYTE;
      2'b01:   entry_in.op = OP_END;
      2'b11:   entry_in.op = OP_BYTE_END;
      default: entry_in.op = OP_BARE;
    endcase
  end

  assign in_ch.ready = (count != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop_taken   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_taken) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop_taken) begin
        count <= count + 1'b1;
      end else if (!push && pop_taken) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    push && !pop_taken |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    wr_ptr == rd_ptr |-> count == '0 || count == CNT_W'(DEPTH))
    else $error("queue pointers and count disagree");
`endif

endmodule

>>> src/wph_back.sv
// ----------------------------------------------------------------------------
// wph_back
// riff/wave chunk walker: while results are taken, runs one queued item per cycle into the result register
// ----------------------------------------------------------------------------
module wph_back
  import wph_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    head,
  output logic       pop,
  wph_out_if.source  out_ch
);

  // parser state
  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] shift_word, shift_word_next;
  logic        seen_fmt, seen_fmt_next;
  logic        seen_data, seen_data_next;
  logic        data_nonempty, data_nonempty_next;
  logic [15:0] fmt_channels, fmt_channels_next;
  logic [31:0] fmt_rate, fmt_rate_next;
  logic [31:0] fmt_avg_rate, fmt_avg_rate_next;
  logic [15:0] fmt_align, fmt_align_next;
  verdict_t    verdict, verdict_next;
  err_t        err, err_next;
  chunk_kind_t chunk_kind, chunk_kind_next;
  logic        format_ok, format_ok_next;

  // result register
  logic        out_valid;
  logic        out_audio_valid, res_audio_valid;
  logic [7:0]  out_audio_byte, res_audio_byte;
  logic        out_restart, res_restart;
  verdict_t    out_verdict;
  err_t        out_error;
  logic [15:0] out_channels;
  logic [31:0] out_rate;
  logic [31:0] out_avg_rate;
  logic [15:0] out_align;

  logic        take_in;
  logic        eof_in;
  logic        align_ok;

  assign pop = head.valid && (!out_valid || out_ch.ready);

  always_comb begin
    unique case (head.entry.op)
      OP_BARE:     begin take_in = 1'b0; eof_in = 1'b0; end
      OP_BYTE:     begin take_in = 1'b1; eof_in = 1'b0; end
      OP_END:      begin take_in = 1'b0; eof_in = 1'b1; end
      OP_BYTE_END: begin take_in = 1'b1; eof_in = 1'b1; end
      default:     begin take_in = 1'b0; eof_in = 1'b0; end
    endcase
  end

  assign align_ok = ({1'b0, fmt_align} == {fmt_channels, 1'b0});

  always_comb begin
    logic [31:0] sw;
    logic [31:0] dec;
    logic        do_finish;
    logic        do_end_chunk;
    logic        do_data_done;

    phase_next         = phase;
    byte_count_next    = byte_count;
    chunk_length_next  = chunk_length;
    shift_word_next    = shift_word;
    seen_fmt_next      = seen_fmt;
    seen_data_next     = seen_data;
    data_nonempty_next = data_nonempty;
    fmt_channels_next  = fmt_channels;
    fmt_rate_next      = fmt_rate;
    fmt_avg_rate_next  = fmt_avg_rate;
    fmt_align_next     = fmt_align;
    verdict_next       = verdict;
    err_next           = err;
    chunk_kind_next    = chunk_kind;
    format_ok_next     = format_ok;
    res_audio_valid    = 1'b0;
    res_audio_byte     = '0;
    res_restart        = 1'b0;
    do_finish          = 1'b0;
    do_end_chunk       = 1'b0;
    do_data_done       = 1'b0;
    sw                 = {head.entry.byte_value, shift_word[31:8]};
    dec                = byte_count - 32'd1;

    if (take_in && verdict == VERDICT_PENDING) begin
      unique case (phase)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
          shift_word_next = sw;
          if (byte_count[1:0] != 2'd3) begin
            byte_count_next = byte_count + 32'd1;
          end else begin
            byte_count_next = '0;
            unique case (phase)
              PH_RIFF: begin
                if (sw != TAG_RIFF) begin
                  verdict_next = VERDICT_FAIL;
                  err_next     = ERR_NO_RIFF;
                  phase_next   = PH_DONE;
                end else begin
                  phase_next = PH_RSIZE;
                end
              end
              PH_RSIZE: phase_next = PH_WAVE;
              PH_WAVE: begin
                if (sw != TAG_WAVE) begin
                  verdict_next = VERDICT_FAIL;
                  err_next     = ERR_NO_WAVE;
                  phase_next   = PH_DONE;
                end else begin
                  phase_next = PH_CID;
                end
              end
              PH_CID: begin
                if (sw == TAG_FMT) begin
                  chunk_kind_next = KIND_FMT;
                end else if (sw == TAG_DATA) begin
                  chunk_kind_next = KIND_DATA;
                end else begin
                  chunk_kind_next = KIND_OTHER;
                end
                phase_next = PH_CSIZE;
              end
              default: begin
                // chunk size complete
                chunk_length_next = sw;
                if (chunk_kind == KIND_FMT) begin
                  phase_next     = PH_FMT;
                  format_ok_next = 1'b1;
                end else if (chunk_kind == KIND_DATA) begin
                  data_nonempty_next = (sw != '0);
                  res_restart        = 1'b1;
                  if (sw == '0) begin
                    do_data_done = 1'b1;
                  end else begin
                    phase_next      = PH_DATA;
                    byte_count_next = sw;
                  end
                end else begin
                  if (sw == '0) begin
                    do_end_chunk = 1'b1;
                  end else begin
                    phase_next      = PH_SKIP;
                    byte_count_next = sw;
                  end
                end
              end
            endcase
          end
        end
        PH_FMT: begin
          shift_word_next = sw;
          byte_count_next = byte_count + 32'd1;
          case (byte_count[3:0])
            4'd1:  if (sw[31:16] != FMT_PCM) format_ok_next = 1'b0;
            4'd3:  fmt_channels_next = sw[31:16];
            4'd7:  fmt_rate_next = sw;
            4'd11: fmt_avg_rate_next = sw;
            4'd13: fmt_align_next = sw[31:16];
            4'd15: begin
              if (!format_ok || sw[31:16] != FMT_BITS) begin
                format_ok_next = 1'b0;
                verdict_next   = VERDICT_FAIL;
                err_next       = ERR_UNSUPPORTED;
                phase_next     = PH_DONE;
              end else begin
                seen_fmt_next = 1'b1;
                if (seen_data) begin
                  do_finish = 1'b1;
                end else if (chunk_length > FMT_BODY_LEN) begin
                  phase_next      = PH_SKIP;
                  byte_count_next = chunk_length - FMT_BODY_LEN;
                end else begin
                  do_end_chunk = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        PH_DATA: begin
          res_audio_valid = 1'b1;
          res_audio_byte  = head.entry.byte_value;
          byte_count_next = dec;
          if (dec == '0) begin
            do_data_done = 1'b1;
          end
        end
        PH_SKIP: begin
          byte_count_next = dec;
          if (dec == '0) begin
            do_end_chunk = 1'b1;
          end
        end
        PH_PAD: begin
          phase_next      = PH_CID;
          byte_count_next = '0;
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    // end of a data chunk
    if (do_data_done) begin
      seen_data_next = 1'b1;
      if (seen_fmt) begin
        do_finish = 1'b1;
      end else begin
        do_end_chunk = 1'b1;
      end
    end

    if (do_end_chunk) begin
      phase_next      = chunk_length_next[0] ? PH_PAD : PH_CID;
      byte_count_next = '0;
    end

    // both chunks seen
    if (do_finish) begin
      phase_next = PH_DONE;
      if (!data_nonempty_next) begin
        verdict_next = VERDICT_FAIL;
        err_next     = ERR_MISSING;
      end else if (!align_ok) begin
        verdict_next = VERDICT_FAIL;
        err_next     = ERR_ALIGN;
      end else begin
        verdict_next = VERDICT_OK;
        err_next     = ERR_NONE;
      end
    end

    // file ended early
    if (eof_in && verdict_next == VERDICT_PENDING) begin
      verdict_next = VERDICT_FAIL;
      if (phase_next == PH_CID || phase_next == PH_SKIP || phase_next == PH_PAD) begin
        err_next = ERR_MISSING;
      end else begin
        err_next = ERR_TRUNCATED;
      end
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && eof_in)) begin
      phase         <= PH_RIFF;
      byte_count    <= '0;
      chunk_length  <= '0;
      shift_word    <= '0;
      seen_fmt      <= 1'b0;
      seen_data     <= 1'b0;
      data_nonempty <= 1'b0;
      fmt_channels  <= '0;
      fmt_rate      <= '0;
      fmt_avg_rate  <= '0;
      fmt_align     <= '0;
      verdict       <= VERDICT_PENDING;
      err           <= ERR_NONE;
      chunk_kind    <= KIND_OTHER;
      format_ok     <= 1'b0;
    end else if (pop) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      chunk_length  <= chunk_length_next;
      shift_word    <= shift_word_next;
      seen_fmt      <= seen_fmt_next;
      seen_data     <= seen_data_next;
      data_nonempty <= data_nonempty_next;
      fmt_channels  <= fmt_channels_next;
      fmt_rate      <= fmt_rate_next;
      fmt_avg_rate  <= fmt_avg_rate_next;
      fmt_align     <= fmt_align_next;
      verdict       <= verdict_next;
      err           <= err_next;
      chunk_kind    <= chunk_kind_next;
      format_ok     <= format_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_audio_valid <= res_audio_valid;
      out_audio_byte  <= res_audio_byte;
      out_restart     <= res_restart;
      out_verdict     <= verdict_next;
      out_error       <= err_next;
      if (verdict_next == VERDICT_OK) begin
        out_channels <= fmt_channels_next;
        out_rate     <= fmt_rate_next;
        out_avg_rate <= fmt_avg_rate_next;
        out_align    <= fmt_align_next;
      end else begin
        out_channels <= '0;
        out_rate     <= '0;
        out_avg_rate <= '0;
        out_align    <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.audio_valid   = out_audio_valid;
  assign out_ch.audio_byte    = out_audio_byte;
  assign out_ch.data_restart  = out_restart;
  assign out_ch.verdict       = out_verdict;
  assign out_ch.error_code    = out_error;
  assign out_ch.channel_count = out_channels;
  assign out_ch.sample_rate   = out_rate;
  assign out_ch.avg_byte_rate = out_avg_rate;
  assign out_ch.block_align   = out_align;

`ifndef NO_ASSERTIONS
  a_eof_rearm: assert property (@(posedge clk) disable iff (rst)
    pop && eof_in |=> phase == PH_RIFF && verdict == VERDICT_PENDING)
    else $error("parser not rearmed after end of file");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) == (verdict != VERDICT_PENDING))
    else $error("done phase and verdict disagree");

  a_fields_gated: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict != VERDICT_OK |-> out_channels == '0 && out_rate == '0)
    else $error("format fields shown without success");

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict == VERDICT_PENDING |-> out_error == ERR_NONE)
    else $error("error code set while pending");
`endif

endmodule
